[src/ttps_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttps_pkg
// Shared types, codes and helpers of the transposition table probe and store.
// ----------------------------------------------------------------------------
package ttps_pkg;

   localparam int TTPS_INDEX_BITS = 16;
   localparam int KEY_W           = 64;
   localparam int ENTRY_W         = 34;
   localparam int WORD_W          = KEY_W + ENTRY_W;
   localparam int CSR_INDEX_W     = 2;
   localparam int CSR_DATA_W      = 15;

   localparam logic [CSR_DATA_W-1:0] MATE_THRESHOLD_RESET = 15'd31000;
   localparam logic [CSR_DATA_W-1:0] INFINITY_SCORE_RESET = 15'd32000;

   // Command codes.
   localparam logic [1:0] CMD_PROBE = 2'd0;
   localparam logic [1:0] CMD_STORE = 2'd1;
   localparam logic [1:0] CMD_CLEAR = 2'd2;

   // Bound kinds.
   localparam logic [1:0] KIND_EXACT = 2'd0;
   localparam logic [1:0] KIND_UPPER = 2'd1;
   localparam logic [1:0] KIND_LOWER = 2'd2;

   // Register indexes of the configuration port.
   localparam logic [CSR_INDEX_W-1:0] CSR_MATE_THRESHOLD = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_INFINITY_SCORE = 2'd1;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LOOKUP
   } state_type;

   typedef struct packed {
      logic capture;   // take the request word and start the table read
      logic finish;    // load the response register, write a store
      logic clr_step;  // write one empty entry of the clearing sweep
   } ctrl_cmd_type;

   typedef struct packed {
      logic out_free;   // response register can take a word this cycle
      logic is_clear;   // held request is a clear command
      logic clear_last; // sweep is at the final entry
   } ctrl_status_type;

   // Clamp an 18-bit signed value to the 16-bit signed range.
   function automatic logic signed [15:0] sat16(input logic signed [17:0] v);
      logic signed [15:0] r;
      if (v > 18'sd32767) begin
         r = 16'sh7FFF;
      end else if (v < -18'sd32768) begin
         r = 16'sh8000;
      end else begin
         r = v[15:0];
      end
      return r;
   endfunction

endpackage

[src/ttps_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttps_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module ttps_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[src/ttps_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttps_ctrl
// Sequencer: clearing sweep, request capture, lookup and response hand-off.
// ----------------------------------------------------------------------------
module ttps_ctrl
   import ttps_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  ctrl_status_type status,
   output ctrl_cmd_type    cmd
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (status.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_LOOKUP;
            end
         end
         ST_LOOKUP: begin
            if (status.out_free) begin
               state_in = status.is_clear ? ST_CLEAR : ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_comb begin
      req_stall    = 1'b1;
      cmd.capture  = 1'b0;
      cmd.finish   = 1'b0;
      cmd.clr_step = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clr_step = 1'b1;
         end
         ST_IDLE: begin
            req_stall   = 1'b0;
            cmd.capture = req_valid;
         end
         ST_LOOKUP: begin
            cmd.finish = status.out_free;
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

endmodule

[src/ttps_datapath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttps_datapath
// Request registers, table memory, score adjustment and response register.
// ----------------------------------------------------------------------------
module ttps_datapath
   import ttps_pkg::*;
#(
   parameter int INDEX_BITS = TTPS_INDEX_BITS
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_valid,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   input  logic [1:0]             req_cmd,
   input  logic [KEY_W-1:0]       req_key,
   input  logic [7:0]             req_best_move,
   input  logic [7:0]             req_search_depth,
   input  logic [7:0]             req_ply,
   input  logic signed [15:0]     req_score,
   input  logic [1:0]             req_bound_kind,
   input  logic signed [15:0]     req_alpha,
   input  logic signed [15:0]     req_beta,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic                   rsp_hit,
   output logic [7:0]             rsp_found_move,
   output logic [1:0]             rsp_found_kind,
   output logic [7:0]             rsp_found_depth,
   output logic signed [15:0]     rsp_found_score,
   output logic signed [15:0]     rsp_new_alpha,
   output logic signed [15:0]     rsp_new_beta,
   input  ctrl_cmd_type           cmd,
   output ctrl_status_type        status
);

   // Configuration registers.
   logic [CSR_DATA_W-1:0] mate_ff;
   logic [CSR_DATA_W-1:0] inf_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mate_ff <= MATE_THRESHOLD_RESET;
         inf_ff  <= INFINITY_SCORE_RESET;
      end else if (csr_valid) begin
         if (csr_index == CSR_MATE_THRESHOLD) begin
            mate_ff <= csr_wdata;
         end else if (csr_index == CSR_INFINITY_SCORE) begin
            inf_ff <= csr_wdata;
         end
      end
   end

   // Request word held for the lookup cycle.
   logic [1:0]         cmd_ff;
   logic [KEY_W-1:0]   key_ff;
   logic [7:0]         move_ff;
   logic [7:0]         depth_ff;
   logic [7:0]         ply_ff;
   logic signed [15:0] score_ff;
   logic [1:0]         kind_ff;
   logic signed [15:0] alpha_ff;
   logic signed [15:0] beta_ff;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         cmd_ff   <= req_cmd;
         key_ff   <= req_key;
         move_ff  <= req_best_move;
         depth_ff <= req_search_depth;
         ply_ff   <= req_ply;
         score_ff <= req_score;
         kind_ff  <= req_bound_kind;
         alpha_ff <= req_alpha;
         beta_ff  <= req_beta;
      end
   end

   // Clearing sweep address; it wraps back to zero at the end of each pass.
   logic [INDEX_BITS-1:0] clr_cnt_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_cnt_ff <= '0;
      end else if (cmd.clr_step) begin
         clr_cnt_ff <= clr_cnt_ff + 1'b1;
      end
   end

   // Table memory: key in the upper bits, packed entry below.
   logic                  wr_en;
   logic [INDEX_BITS-1:0] wr_addr;
   logic [WORD_W-1:0]     wr_data;
   logic [WORD_W-1:0]     rd_data;
   logic signed [15:0]    store_score;

   ttps_ram #(
      .WIDTH(WORD_W),
      .DEPTH(2 ** INDEX_BITS)
   ) u_table (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_en  (cmd.capture),
      .rd_addr(req_key[INDEX_BITS-1:0]),
      .rd_data(rd_data)
   );

   always_comb begin
      logic signed [17:0] v;
      logic signed [17:0] mate_x;
      logic signed [17:0] inf_x;
      logic signed [17:0] ply_x;
      v      = 18'(score_ff);
      mate_x = signed'({3'b000, mate_ff});
      inf_x  = signed'({3'b000, inf_ff});
      ply_x  = signed'({10'd0, ply_ff});
      // A mate score is pushed away from zero by the distance from the root.
      if (v > mate_x && v <= inf_x) begin
         store_score = sat16(v + ply_x);
      end else if (v < -mate_x && v >= -inf_x) begin
         store_score = sat16(v - ply_x);
      end else begin
         store_score = score_ff;
      end
   end

   always_comb begin
      if (cmd.clr_step) begin
         wr_en   = 1'b1;
         wr_addr = clr_cnt_ff;
         wr_data = '0;
      end else begin
         wr_en   = cmd.finish && (cmd_ff == CMD_STORE);
         wr_addr = key_ff[INDEX_BITS-1:0];
         wr_data = {key_ff, store_score, depth_ff, kind_ff, move_ff};
      end
   end

   // Probe evaluation on the word read back from the table.
   logic               hit_in;
   logic [7:0]         fmove_in;
   logic [1:0]         fkind_in;
   logic [7:0]         fdepth_in;
   logic signed [15:0] fscore_in;
   logic signed [15:0] alpha_in;
   logic signed [15:0] beta_in;

   always_comb begin
      logic signed [17:0] v;
      logic signed [17:0] mate_x;
      logic signed [17:0] inf_x;
      logic signed [17:0] ply_x;
      logic signed [15:0] adj;
      mate_x = signed'({3'b000, mate_ff});
      inf_x  = signed'({3'b000, inf_ff});
      ply_x  = signed'({10'd0, ply_ff});
      hit_in    = (cmd_ff == CMD_PROBE) && (rd_data[WORD_W-1:ENTRY_W] == key_ff);
      fmove_in  = '0;
      fkind_in  = '0;
      fdepth_in = '0;
      fscore_in = '0;
      alpha_in  = alpha_ff;
      beta_in   = beta_ff;
      v         = 18'(signed'(rd_data[33:18]));
      if (v > mate_x && v <= inf_x) begin
         adj = sat16(v - ply_x);
      end else if (v < -mate_x && v >= -inf_x) begin
         adj = sat16(v + ply_x);
      end else begin
         adj = rd_data[33:18];
      end
      if (hit_in) begin
         fmove_in  = rd_data[7:0];
         fkind_in  = rd_data[9:8];
         fdepth_in = rd_data[17:10];
         fscore_in = rd_data[33:18];
         // Only an entry searched at least as deep may narrow the window.
         if (rd_data[17:10] >= depth_ff) begin
            if (rd_data[9:8] == KIND_EXACT) begin
               alpha_in = adj;
               beta_in  = adj;
            end else if (rd_data[9:8] == KIND_UPPER && adj <= alpha_ff) begin
               beta_in = alpha_ff;
            end else if (rd_data[9:8] == KIND_LOWER && adj >= beta_ff) begin
               alpha_in = beta_ff;
            end
         end
      end
   end

   // Response register.
   logic               rsp_valid_ff;
   logic               hit_ff;
   logic [7:0]         fmove_ff;
   logic [1:0]         fkind_ff;
   logic [7:0]         fdepth_ff;
   logic signed [15:0] fscore_ff;
   logic signed [15:0] nalpha_ff;
   logic signed [15:0] nbeta_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.finish) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         hit_ff    <= hit_in;
         fmove_ff  <= fmove_in;
         fkind_ff  <= fkind_in;
         fdepth_ff <= fdepth_in;
         fscore_ff <= fscore_in;
         nalpha_ff <= alpha_in;
         nbeta_ff  <= beta_in;
      end
   end

   assign status.out_free   = !rsp_valid_ff || !rsp_stall;
   assign status.is_clear   = (cmd_ff == CMD_CLEAR);
   assign status.clear_last = &clr_cnt_ff;

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_hit         = hit_ff;
   assign rsp_found_move  = fmove_ff;
   assign rsp_found_kind  = fkind_ff;
   assign rsp_found_depth = fdepth_ff;
   assign rsp_found_score = fscore_ff;
   assign rsp_new_alpha   = nalpha_ff;
   assign rsp_new_beta    = nbeta_ff;

endmodule

[src/transposition_table_probe_store_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// transposition_table_probe_store_top
// Direct-mapped transposition table with mate-score adjustment and cutoffs.
// ----------------------------------------------------------------------------
// A probe or store word is accepted while the sequencer is idle and the
// table is read in that cycle; the result is evaluated and registered in
// the lookup state, where a store also writes its entry; a full
// response register that is stalled holds the block in the lookup cycle.
// A clear command returns its response and then sweeps the table write port
// one entry per cycle through all 2**INDEX_BITS entries (65536 at the
// default), with req_stall high. The same sweep runs straight after reset.
// Configuration writes are accepted on every cycle.
module transposition_table_probe_store_top
   import ttps_pkg::*;
#(
   parameter int INDEX_BITS = TTPS_INDEX_BITS
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [1:0]             req_cmd,
   input  logic [KEY_W-1:0]       req_key,
   input  logic [7:0]             req_best_move,
   input  logic [7:0]             req_search_depth,
   input  logic [7:0]             req_ply,
   input  logic signed [15:0]     req_score,
   input  logic [1:0]             req_bound_kind,
   input  logic signed [15:0]     req_alpha,
   input  logic signed [15:0]     req_beta,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic                   rsp_hit,
   output logic [7:0]             rsp_found_move,
   output logic [1:0]             rsp_found_kind,
   output logic [7:0]             rsp_found_depth,
   output logic signed [15:0]     rsp_found_score,
   output logic signed [15:0]     rsp_new_alpha,
   output logic signed [15:0]     rsp_new_beta
);

   ctrl_cmd_type    ctrl_cmd;
   ctrl_status_type ctrl_status;

   assign csr_ready = 1'b1;

   ttps_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .status   (ctrl_status),
      .cmd      (ctrl_cmd)
   );

   ttps_datapath #(
      .INDEX_BITS(INDEX_BITS)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .csr_valid       (csr_valid),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .req_cmd         (req_cmd),
      .req_key         (req_key),
      .req_best_move   (req_best_move),
      .req_search_depth(req_search_depth),
      .req_ply         (req_ply),
      .req_score       (req_score),
      .req_bound_kind  (req_bound_kind),
      .req_alpha       (req_alpha),
      .req_beta        (req_beta),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_hit         (rsp_hit),
      .rsp_found_move  (rsp_found_move),
      .rsp_found_kind  (rsp_found_kind),
      .rsp_found_depth (rsp_found_depth),
      .rsp_found_score (rsp_found_score),
      .rsp_new_alpha   (rsp_new_alpha),
      .rsp_new_beta    (rsp_new_beta),
      .cmd             (ctrl_cmd),
      .status          (ctrl_status)
   );

`ifndef SYNTHESIS
   // The table is swept clean after reset before any word is taken.
   a_reset_sweep: assert property (@(posedge clock) reset |=> req_stall)
      else $error("request accepted straight after reset");

   // At most one word is in flight, so captures never fall on adjacent edges.
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      ctrl_cmd.capture |=> !ctrl_cmd.capture)
      else $error("second word captured during a lookup");

   // A finished lookup always lands in the response register.
   a_finish_valid: assert property (@(posedge clock) disable iff (reset)
      ctrl_cmd.finish |=> rsp_valid)
      else $error("finished lookup did not raise rsp_valid");

   // Once started, the clearing sweep runs through to its final entry.
   a_sweep_runs: assert property (@(posedge clock) disable iff (reset)
      ctrl_cmd.clr_step && !ctrl_status.clear_last |=> ctrl_cmd.clr_step)
      else $error("clearing sweep stopped early");
`endif

endmodule
